// File: hdl/mmis_pkg.sv
// mmis_pkg: shared types and constants for the max/min interleave sorter
// holds the queued item struct and the back-end state enum
// depends on nothing
package mmis_pkg;

   // width of one list element
   localparam int VALUE_W = 31;

   // one list element as it travels from the front end to the sorted chain
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } item_type;

   // back-end phases: loading into the chain, or emitting the list
   typedef enum logic {
      ST_LOAD  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

endpackage

// File: hdl/mmis_front.sv
// mmis_front: input side of the max/min interleave sorter
// accepts request transfers and buffers them in a two-entry queue
// depends on mmis_pkg
module mmis_front (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [30:0] value, [31] zero fill
   input  logic                  req_tlast,   // last_in
   // queued items toward the sorted chain
   output logic                  item_valid,
   input  logic                  item_ready,
   output mmis_pkg::item_type    item
);
   import mmis_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   item_type   req_item;

   // classify the incoming transfer into an item
   assign req_item.value = req_tdata[VALUE_W-1:0];
   assign req_item.last  = req_tlast;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (fill_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = entry_ff[rd_ptr_ff];

   // queue pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// File: hdl/mmis_chain.sv
// mmis_chain: back end of the max/min interleave sorter
// sorted insertion chain, two-ended readout and the response register
// depends on mmis_pkg
module mmis_chain #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // queued items from the front end
   input  logic                  item_valid,
   output logic                  item_ready,
   input  mmis_pkg::item_type    item,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [30:0] out_value, [31] zero fill
   output logic                  rsp_tlast,   // last_out
   output logic                  rsp_tuser    // dropped
);
   import mmis_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   logic [VALUE_W-1:0] cell_ff [MAX_ITEMS];
   logic [VALUE_W-1:0] cell_in [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] gt;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic               full, pop, insert, emit, shift_min, out_free;
   logic [CNT_W-1:0]   cnt_m1;
   logic [IDX_W-1:0]   hi_idx;

   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign item_ready = (state_ff == ST_LOAD);
   assign pop       = item_valid && item_ready;
   assign insert    = pop && !full;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = (state_ff == ST_DRAIN) && out_free;
   assign shift_min = emit && phase_ff;
   assign cnt_m1    = count_ff - 1'b1;
   assign hi_idx    = cnt_m1[IDX_W-1:0];

   // per-cell compare against the arriving value
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] > item.value);
      end
   end

   // next value of each cell: insert with shift up, or shift down after a min read
   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      logic               prev_gt;
      logic [VALUE_W-1:0] prev_val;
      logic [VALUE_W-1:0] next_val;

      if (g == 0) begin : g_first
         assign prev_gt  = 1'b0;
         assign prev_val = '0;
      end else begin : g_rest
         assign prev_gt  = gt[g-1];
         assign prev_val = cell_ff[g-1];
      end

      if (g == MAX_ITEMS - 1) begin : g_top
         assign next_val = cell_ff[g];
      end else begin : g_mid
         assign next_val = cell_ff[g+1];
      end

      always_comb begin
         cell_in[g] = cell_ff[g];
         if (insert && (CNT_W'(g) <= count_ff)) begin
            if (prev_gt) begin
               cell_in[g] = prev_val;
            end else if (gt[g] || (CNT_W'(g) == count_ff)) begin
               cell_in[g] = item.value;
            end
         end else if (shift_min) begin
            cell_in[g] = next_val;
         end
      end
   end

   // load and drain sequencing
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (item.last) begin
                  state_in = ST_DRAIN;
                  phase_in = 1'b0;
               end
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = phase_ff ? cell_ff[0] : cell_ff[hi_idx];
               rsp_last_in  = (count_ff == CNT_W'(1));
               rsp_drop_in  = ovf_ff;
               count_in     = cnt_m1;
               phase_in     = ~phase_ff;
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // chain cells and response payload, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - VALUE_W){1'b0}}, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

   // fill level never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("chain fill level beyond capacity");

   // draining always has at least one element left
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("drain with empty chain");

   // the final transfer of a list leaves the chain empty and loading
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (emit && (count_ff == CNT_W'(1))) |=>
         ((state_ff == ST_LOAD) && (count_ff == '0) && !ovf_ff && rsp_tlast))
      else $error("list end did not clear the chain");

endmodule

// File: hdl/max_min_interleave_sorter_unit.sv
// max_min_interleave_sorter_unit: sorts a list and returns it as max, min, max, min, ...
// data path: accepted items wait in the two-entry queue until the chain takes them; the
// flagged last item moves the chain to drain, and results are then registered onto rsp
// throughput: one item a cycle while loading (one insertion step of the sorted chain), then
// one result a cycle while draining unless rsp stalls; no item enters the chain in readout
// reset: synchronous, active high; empties the queue and the chain, no response pending
module max_min_interleave_sorter_unit #(
   parameter int MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] value, [31] zero fill
   input  logic        req_tlast,   // last_in
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] out_value, [31] zero fill
   output logic        rsp_tlast,   // last_out
   output logic        rsp_tuser    // dropped
);
   import mmis_pkg::*;

   logic     item_valid;
   logic     item_ready;
   item_type item;

   // input queue
   mmis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // sorted chain and readout
   mmis_chain #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
